/* sv/hq_pkg.sv */
// hq_pkg: shared types, codes and defaults of the heap priority queue
`timescale 1ns / 1ps
package hq_pkg;

  localparam int DEPTH_DEF        = 64;
  localparam int PRIORITY_BITS_DEF = 32;
  localparam int PAYLOAD_BITS_DEF  = 16;

  localparam int       CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] ACT_ENQ = 2'd0;
  localparam logic [1:0] ACT_DEQ = 2'd1;
  localparam logic [1:0] ACT_SET = 2'd2;
  localparam logic [1:0] ACT_RD  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] priority_req;
    logic [15:0]        payload;
    logic [5:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        payload_out;
    logic signed [31:0] priority_out;
    logic [6:0]         count;
    logic signed [31:0] top_priority;
    logic               is_empty;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_SET,
    OP_RD
  } op_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEQ_LD,
    S_SET_LD,
    S_RD_LD,
    S_UP,
    S_UP_CMP,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DONE
  } state_t;

endpackage

/* sv/binary_max_heap_priority_queue.sv */
// binary_max_heap_priority_queue: top level with configuration register
//
// usage:
// - in_valid/in_stall/in_data carry one action per transaction: enqueue,
//   dequeue, set priority at a position or read priority at a position
// - out_valid/out_stall/out_data return exactly one result per action with
//   status, removed or old priority, count and root priority
// - cfg_* is an APB-style port holding the capacity register at address 0
// - a two-entry command queue decouples intake from the heap sequencer, so
//   up to two actions are taken while the sequencer is busy
// - full, empty and bad position go straight to the result; a read fetches
//   one entry; enqueue and a raised priority climb level by level, and
//   dequeue and a lowered priority descend level by level, paced by the
//   single read port of the heap memory (one parent or child fetch per
//   cycle); the next action starts after the result
// - reset empties the heap and sets capacity to 64; entries need no clear
// - when out_stall is high the result holds and the sequencer waits in its
//   final state; the command queue keeps taking actions until it is full
`timescale 1ns / 1ps
module binary_max_heap_priority_queue #(
  parameter int DEPTH         = hq_pkg::DEPTH_DEF,
  parameter int PRIORITY_BITS = hq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = hq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hq_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hq_pkg::out_item_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [hq_pkg::CAP_W-1:0] cap_r;
  logic                     cmd_valid, cmd_take;
  hq_pkg::cmd_t             cmd;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= hq_pkg::CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      cap_r <= cfg_pwdata[hq_pkg::CAP_W-1:0];
    end
  end

  hq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  hq_back #(
    .DEPTH         (DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .capacity  (cap_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_empty_status : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == hq_pkg::STAT_EMPTY |->
      out_data.is_empty && out_data.payload_out == '0)
    else $error("empty status with entries or payload");

  a_empty_top : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.top_priority == '0)
    else $error("top priority nonzero on empty heap");

  a_bad_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == hq_pkg::STAT_BAD |-> out_data.priority_out == '0)
    else $error("bad position returned a priority");
`endif

endmodule

/* sv/hq_front.sv */
// hq_front: input capture, action decode and two-entry command queue
`timescale 1ns / 1ps
module hq_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hq_pkg::in_item_t in_data,
  output logic             cmd_valid,
  output hq_pkg::cmd_t     cmd,
  input  logic             cmd_take
);

  hq_pkg::cmd_t q_mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push, pop;
  hq_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.item = in_data;
    unique case (in_data.action)
      hq_pkg::ACT_ENQ: cmd_in.op = hq_pkg::OP_ENQ;
      hq_pkg::ACT_DEQ: cmd_in.op = hq_pkg::OP_DEQ;
      hq_pkg::ACT_SET: cmd_in.op = hq_pkg::OP_SET;
      default:         cmd_in.op = hq_pkg::OP_RD;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* sv/hq_back.sv */
// hq_back: heap storage, sift sequencer and result register
`timescale 1ns / 1ps
module hq_back #(
  parameter int DEPTH         = hq_pkg::DEPTH_DEF,
  parameter int PRIORITY_BITS = hq_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = hq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  input  hq_pkg::cmd_t             cmd,
  output logic                     cmd_take,
  input  logic [hq_pkg::CAP_W-1:0] capacity,
  output logic                     out_valid,
  input  logic                     out_stall,
  output hq_pkg::out_item_t        out_data
);

  localparam int PB = PRIORITY_BITS;
  localparam int QB = PAYLOAD_BITS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = CW + 1;
  localparam int XW = (IW > 8) ? IW : 8;

  logic signed [PB-1:0] mem_pri [DEPTH];
  logic [QB-1:0]        mem_pay [DEPTH];

  hq_pkg::state_t       state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        c_r, c_nxt;
  logic signed [PB-1:0] itm_pri_r, itm_pri_nxt;
  logic [QB-1:0]        itm_pay_r, itm_pay_nxt;
  logic signed [PB-1:0] lpri_r, lpri_nxt;
  logic [QB-1:0]        lpay_r, lpay_nxt;
  logic [1:0]           res_stat_r, res_stat_nxt;
  logic signed [PB-1:0] res_pri_r, res_pri_nxt;
  logic [QB-1:0]        res_pay_r, res_pay_nxt;
  logic signed [PB-1:0] root_pri_r;
  logic [QB-1:0]        root_pay_r;
  logic signed [PB-1:0] rd_pri_r;
  logic [QB-1:0]        rd_pay_r;
  logic                 out_valid_r;
  hq_pkg::out_item_t    out_data_r;

  logic                 mem_we;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic signed [PB-1:0] mem_wpri;
  logic [QB-1:0]        mem_wpay;
  logic                 out_load;
  logic                 full, pos_ok;
  logic signed [PB-1:0] req_p, ch_pri;
  logic [QB-1:0]        ch_pay;
  logic [IW-1:0]        ch_idx, c_calc;
  logic                 ch_go;

  always_comb begin
    req_p  = PB'($signed(cmd.item.priority_req));
    full   = (XW'(count_r) >= XW'(capacity)) || (XW'(count_r) >= XW'(DEPTH));
    pos_ok = XW'(cmd.item.position) < XW'(count_r);
    c_calc = {idx_r, 1'b1};

    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    c_nxt        = c_r;
    itm_pri_nxt  = itm_pri_r;
    itm_pay_nxt  = itm_pay_r;
    lpri_nxt     = lpri_r;
    lpay_nxt     = lpay_r;
    res_stat_nxt = res_stat_r;
    res_pri_nxt  = res_pri_r;
    res_pay_nxt  = res_pay_r;
    mem_we       = 1'b0;
    mem_wa       = AW'(idx_r);
    mem_wpri     = itm_pri_r;
    mem_wpay     = itm_pay_r;
    mem_ra       = '0;
    cmd_take     = 1'b0;
    out_load     = 1'b0;
    ch_pri       = rd_pri_r;
    ch_pay       = rd_pay_r;
    ch_idx       = c_r;
    ch_go        = 1'b0;

    unique case (state_r)
      hq_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_take     = 1'b1;
          res_stat_nxt = hq_pkg::STAT_OK;
          res_pri_nxt  = '0;
          res_pay_nxt  = '0;
          itm_pri_nxt  = req_p;
          itm_pay_nxt  = QB'(cmd.item.payload);
          idx_nxt      = CW'(cmd.item.position);
          unique case (cmd.op)
            hq_pkg::OP_ENQ: begin
              if (full) begin
                res_stat_nxt = hq_pkg::STAT_FULL;
                state_nxt    = hq_pkg::S_DONE;
              end else begin
                idx_nxt   = count_r;
                count_nxt = count_r + 1'b1;
                state_nxt = hq_pkg::S_UP;
              end
            end
            hq_pkg::OP_DEQ: begin
              if (count_r == '0) begin
                res_stat_nxt = hq_pkg::STAT_EMPTY;
                state_nxt    = hq_pkg::S_DONE;
              end else begin
                res_pri_nxt = root_pri_r;
                res_pay_nxt = root_pay_r;
                count_nxt   = count_r - 1'b1;
                mem_ra      = AW'(count_r - 1'b1);
                state_nxt   = (count_r == CW'(1)) ? hq_pkg::S_DONE : hq_pkg::S_DEQ_LD;
              end
            end
            default: begin
              if (!pos_ok) begin
                res_stat_nxt = hq_pkg::STAT_BAD;
                state_nxt    = hq_pkg::S_DONE;
              end else begin
                mem_ra    = AW'(cmd.item.position);
                state_nxt = (cmd.op == hq_pkg::OP_SET) ? hq_pkg::S_SET_LD : hq_pkg::S_RD_LD;
              end
            end
          endcase
        end
      end
      hq_pkg::S_DEQ_LD: begin
        itm_pri_nxt = rd_pri_r;
        itm_pay_nxt = rd_pay_r;
        idx_nxt     = '0;
        state_nxt   = hq_pkg::S_DN;
      end
      hq_pkg::S_RD_LD: begin
        res_pri_nxt = rd_pri_r;
        state_nxt   = hq_pkg::S_DONE;
      end
      hq_pkg::S_SET_LD: begin
        res_pri_nxt = rd_pri_r;
        itm_pay_nxt = rd_pay_r;
        if (itm_pri_r < rd_pri_r) begin
          state_nxt = hq_pkg::S_DN;
        end else if (itm_pri_r > rd_pri_r) begin
          state_nxt = hq_pkg::S_UP;
        end else begin
          state_nxt = hq_pkg::S_DONE;
        end
      end
      hq_pkg::S_UP: begin
        if (idx_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = hq_pkg::S_DONE;
        end else begin
          c_nxt     = IW'((idx_r - 1'b1) >> 1);
          mem_ra    = AW'((idx_r - 1'b1) >> 1);
          state_nxt = hq_pkg::S_UP_CMP;
        end
      end
      hq_pkg::S_UP_CMP: begin
        mem_we = 1'b1;
        if (rd_pri_r >= itm_pri_r) begin
          state_nxt = hq_pkg::S_DONE;
        end else begin
          mem_wpri  = rd_pri_r;
          mem_wpay  = rd_pay_r;
          idx_nxt   = CW'(c_r);
          state_nxt = hq_pkg::S_UP;
        end
      end
      hq_pkg::S_DN: begin
        c_nxt = c_calc;
        if (c_calc >= IW'(count_r)) begin
          mem_we    = 1'b1;
          state_nxt = hq_pkg::S_DONE;
        end else begin
          mem_ra    = AW'(c_calc);
          state_nxt = hq_pkg::S_DN_L;
        end
      end
      hq_pkg::S_DN_L: begin
        if (c_r + 1'b1 < IW'(count_r)) begin
          lpri_nxt  = rd_pri_r;
          lpay_nxt  = rd_pay_r;
          mem_ra    = AW'(c_r + 1'b1);
          state_nxt = hq_pkg::S_DN_R;
        end else begin
          ch_go = 1'b1;
        end
      end
      hq_pkg::S_DN_R: begin
        ch_go = 1'b1;
        if (!(lpri_r < rd_pri_r)) begin
          ch_pri = lpri_r;
          ch_pay = lpay_r;
        end else begin
          ch_idx = c_r + 1'b1;
        end
      end
      hq_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = hq_pkg::S_IDLE;
        end
      end
      default: state_nxt = hq_pkg::S_IDLE;
    endcase

    if (ch_go) begin
      mem_we = 1'b1;
      if (itm_pri_r >= ch_pri) begin
        state_nxt = hq_pkg::S_DONE;
      end else begin
        mem_wpri  = ch_pri;
        mem_wpay  = ch_pay;
        idx_nxt   = CW'(ch_idx);
        state_nxt = hq_pkg::S_DN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    c_r        <= c_nxt;
    itm_pri_r  <= itm_pri_nxt;
    itm_pay_r  <= itm_pay_nxt;
    lpri_r     <= lpri_nxt;
    lpay_r     <= lpay_nxt;
    res_stat_r <= res_stat_nxt;
    res_pri_r  <= res_pri_nxt;
    res_pay_r  <= res_pay_nxt;
    if (mem_we && mem_wa == '0) begin
      root_pri_r <= mem_wpri;
      root_pay_r <= mem_wpay;
    end
    if (out_load) begin
      out_data_r.status       <= res_stat_r;
      out_data_r.payload_out  <= 16'(res_pay_r);
      out_data_r.priority_out <= 32'(res_pri_r);
      out_data_r.count        <= 7'(count_r);
      out_data_r.top_priority <= (count_r != '0) ? 32'(root_pri_r) : '0;
      out_data_r.is_empty     <= (count_r == '0);
    end
  end

  // heap storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_pri[mem_wa] <= mem_wpri;
      mem_pay[mem_wa] <= mem_wpay;
    end
    rd_pri_r <= mem_pri[mem_ra];
    rd_pay_r <= mem_pay[mem_ra];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* bench/binary_max_heap_priority_queue_tb.sv */
// binary_max_heap_priority_queue_tb: self-checking bench with heap predictor and random traffic
`timescale 1ns / 1ps
module binary_max_heap_priority_queue_tb;

  localparam int HEAP_SLOTS = 64;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hq_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hq_pkg::out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  binary_max_heap_priority_queue i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] heap_pri [HEAP_SLOTS];
  logic [15:0] heap_tag [HEAP_SLOTS];
  int unsigned heap_count;
  int unsigned heap_cap;

  hq_pkg::in_item_t pending_actions [$];
  hq_pkg::out_item_t expected_results [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned hold_off;
  bit long_hold_req;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic signed [31:0] p;
    logic [15:0] t;
    p = heap_pri[a]; heap_pri[a] = heap_pri[b]; heap_pri[b] = p;
    t = heap_tag[a]; heap_tag[a] = heap_tag[b]; heap_tag[b] = t;
  endfunction

  function automatic void climb(int unsigned i);
    int unsigned up;
    while (i > 0) begin
      up = (i - 1) / 2;
      if (heap_pri[up] >= heap_pri[i]) break;
      swap_slots(up, i);
      i = up;
    end
  endfunction

  function automatic void descend(int unsigned i);
    int unsigned c;
    while (1) begin
      c = 2 * i + 1;
      if (c >= heap_count) break;
      if (c + 1 < heap_count && heap_pri[c] < heap_pri[c + 1]) c++;
      if (heap_pri[i] >= heap_pri[c]) break;
      swap_slots(i, c);
      i = c;
    end
  endfunction

  function automatic hq_pkg::out_item_t apply_action(hq_pkg::in_item_t a);
    hq_pkg::out_item_t r;
    int unsigned lim;
    logic signed [31:0] old;
    r = '0;
    lim = heap_cap < HEAP_SLOTS ? heap_cap : HEAP_SLOTS;
    case (a.action)
      hq_pkg::ACT_ENQ: begin
        if (heap_count >= lim) r.status = hq_pkg::STAT_FULL;
        else begin
          heap_pri[heap_count] = a.priority_req;
          heap_tag[heap_count] = a.payload;
          climb(heap_count);
          heap_count++;
        end
      end
      hq_pkg::ACT_DEQ: begin
        if (heap_count == 0) r.status = hq_pkg::STAT_EMPTY;
        else begin
          r.payload_out = heap_tag[0];
          r.priority_out = heap_pri[0];
          heap_count--;
          if (heap_count > 0) begin
            heap_pri[0] = heap_pri[heap_count];
            heap_tag[0] = heap_tag[heap_count];
          end
          descend(0);
        end
      end
      default: begin
        if (a.position >= heap_count) r.status = hq_pkg::STAT_BAD;
        else if (a.action == hq_pkg::ACT_RD) r.priority_out = heap_pri[a.position];
        else begin
          old = heap_pri[a.position];
          r.priority_out = old;
          heap_pri[a.position] = a.priority_req;
          if (a.priority_req < old) descend(a.position);
          else if (a.priority_req > old) climb(a.position);
        end
      end
    endcase
    r.status = r.status;
    r.count = heap_count[6:0];
    r.top_priority = heap_count > 0 ? heap_pri[0] : '0;
    r.is_empty = heap_count == 0;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_priority();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 15)));
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic hq_pkg::in_item_t make_action(logic [1:0] act, int unsigned depth_hint);
    hq_pkg::in_item_t a;
    a.action = act;
    a.priority_req = rand_priority();
    a.payload = 16'($urandom());
    a.position = ($urandom_range(0, 3) == 0 || depth_hint == 0) ?
                 6'($urandom()) : 6'($urandom_range(0, depth_hint - 1));
    return a;
  endfunction

  function automatic int unsigned rand_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_action(in_data));
        void'(pending_actions.pop_front());
        send_gap <= rand_gap();
        if (pending_actions.size() > 0 && rand_gap() == 0) begin
          in_data <= pending_actions[0];
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (pending_actions.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_actions[0];
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transaction: got %p", out_data);
        end else if (out_data !== expected_results[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p got %p", expected_results[0], out_data);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (long_hold_req && hold_off == 0) begin
        hold_off <= 300;
        out_stall <= 1'b1;
      end else if (hold_off > 1) begin
        hold_off <= hold_off - 1;
      end else if (hold_off == 1) begin
        hold_off <= 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0) ||
                     (out_stall && $urandom_range(0, 7) == 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_capacity(int unsigned value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= '0; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    heap_cap = value & 32'h7f;
  endtask

  task automatic drain();
    while (pending_actions.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned n, int unsigned enq_bias);
    int unsigned sim_count;
    int unsigned r;
    logic [1:0] act;
    sim_count = heap_count;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < enq_bias) act = hq_pkg::ACT_ENQ;
      else if (r < enq_bias + 25) act = hq_pkg::ACT_DEQ;
      else if (r < enq_bias + 40) act = hq_pkg::ACT_SET;
      else act = hq_pkg::ACT_RD;
      pending_actions.push_back(make_action(act, sim_count));
      if (act == hq_pkg::ACT_ENQ && sim_count < 64) sim_count++;
      if (act == hq_pkg::ACT_DEQ && sim_count > 0) sim_count--;
    end
    drain();
  endtask

  initial begin
    hq_pkg::in_item_t a;
    heap_count = 0;
    heap_cap = 64;
    mismatch_count = 0;
    send_gap = 0;
    hold_off = 0;
    long_hold_req = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, extremes, full, equal priorities
    a = '0; a.action = hq_pkg::ACT_DEQ; pending_actions.push_back(a);
    a.action = hq_pkg::ACT_RD; pending_actions.push_back(a);
    a.action = hq_pkg::ACT_SET; pending_actions.push_back(a);
    a = '0; a.action = hq_pkg::ACT_ENQ; a.priority_req = 32'sh7fffffff; a.payload = 16'hffff;
    pending_actions.push_back(a);
    a.priority_req = 32'sh80000000; a.payload = 16'h0000; pending_actions.push_back(a);
    a.priority_req = 5; a.payload = 16'h1234; pending_actions.push_back(a);
    a.priority_req = 5; a.payload = 16'h4321; pending_actions.push_back(a);
    a.action = hq_pkg::ACT_RD; a.position = 2; pending_actions.push_back(a);
    a.action = hq_pkg::ACT_RD; a.position = 6'h3f; pending_actions.push_back(a);
    a.action = hq_pkg::ACT_SET; a.position = 2; a.priority_req = 5; pending_actions.push_back(a);
    a.action = hq_pkg::ACT_SET; a.position = 0; a.priority_req = 32'sh80000000;
    pending_actions.push_back(a);
    a.action = hq_pkg::ACT_SET; a.position = 3; a.priority_req = 32'sh7fffffff;
    pending_actions.push_back(a);
    a.action = hq_pkg::ACT_DEQ; pending_actions.push_back(a);
    drain();
    write_capacity(1);
    a = '0; a.action = hq_pkg::ACT_ENQ; pending_actions.push_back(a);
    a.action = hq_pkg::ACT_DEQ; pending_actions.push_back(a);
    pending_actions.push_back(a);
    pending_actions.push_back(a);
    a.action = hq_pkg::ACT_ENQ; a.priority_req = -3; pending_actions.push_back(a);
    a.priority_req = 9; pending_actions.push_back(a);
    drain();
    write_capacity(0);
    a.action = hq_pkg::ACT_ENQ; pending_actions.push_back(a);
    drain();

    // random phases over several capacities, long receiver hold in the fill phase
    write_capacity(64);
    long_hold_req = 1;
    run_phase(200, 60);
    long_hold_req = 0;
    write_capacity(127);
    run_phase(150, 45);
    write_capacity(7);
    run_phase(120, 40);
    write_capacity(2);
    run_phase(60, 40);
    write_capacity(64);
    run_phase(200, 35);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
